// ===== rtl/pia_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pia_pkg
// Shared widths, function and status codes, and the control/status bundles
// between the page index allocator controller and datapath.
// ---------------------------------------------------------------------------
package pia_pkg;

    localparam int POOL_PAGES = 1024;
    localparam int MAX_BATCH  = 64;

    localparam int PAGE_W  = 10;   // granted index / freed index
    localparam int CNT_W   = 11;   // bump pointer, stack depth, totals
    localparam int BATCH_W = 7;    // batch_count
    localparam int FUNC_W  = 2;
    localparam int STAT_W  = 2;

    localparam logic [FUNC_W-1:0] FN_ALLOC = 2'd0;
    localparam logic [FUNC_W-1:0] FN_FREE  = 2'd1;
    localparam logic [FUNC_W-1:0] FN_BATCH = 2'd2;

    localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
    localparam logic [STAT_W-1:0] ST_EXHAUSTED = 2'd1;
    localparam logic [STAT_W-1:0] ST_DROPPED   = 2'd2;

    // controller -> datapath
    typedef struct packed {
        logic accept;   // take the input beat
        logic emit;     // emit one grant of the running allocation
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic out_free;    // output register can be loaded this cycle
        logic alloc_go;    // input beat starts a grant sequence
        logic last_grant;  // the grant being emitted is the final one
    } t_status;

endpackage

// ===== rtl/page_index_allocator.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// page_index_allocator
// Hands out page indices from a LIFO free stack backed by a bump pointer.
// ---------------------------------------------------------------------------
// Input channel (i_valid / o_stall): one beat is an allocate, a free, or a
// batch allocate of up to 64 indices (larger counts saturate to 64).
// Output channel (o_valid / i_stall): one beat per result, o_last marks the
// final result of an input beat; every beat carries the totals as they stand
// after the whole input beat.
// Free, exhausted-pool results: the result is registered at the accept edge,
// and the next beat can be taken while it is shown unless the receiver stalls.
// Allocate of N indices (single = 1): accept cycle, then one grant per cycle
// while the output is taken. The free stack memory is prefetched at the accept
// cycle and read again with every popped grant.
// Batch of zero and unused function codes are accepted with no result.
// Reset empties the pool (bump pointer and stack depth to zero); no clearing
// pass is needed. While the receiver stalls, the output beat holds and the
// input side stalls once the output register is full.
// ---------------------------------------------------------------------------
module page_index_allocator (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic [pia_pkg::FUNC_W-1:0]          i_func,
    input  logic [pia_pkg::PAGE_W-1:0]          i_free_page,
    input  logic [pia_pkg::BATCH_W-1:0]         i_batch_count,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic [pia_pkg::PAGE_W-1:0]          o_granted_index,
    output logic                                o_index_valid,
    output logic                                o_last,
    output logic [pia_pkg::STAT_W-1:0]          o_status,
    output logic [pia_pkg::CNT_W-1:0]           o_allocated_total,
    output logic [pia_pkg::CNT_W-1:0]           o_free_total
);

    pia_pkg::t_cmd    cmd;
    pia_pkg::t_status status;

    pia_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .i_status (status),
        .o_stall  (o_stall),
        .o_cmd    (cmd)
    );

    pia_dpath u_dpath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .o_status          (status),
        .i_func            (i_func),
        .i_free_page       (i_free_page),
        .i_batch_count     (i_batch_count),
        .i_stall           (i_stall),
        .o_valid           (o_valid),
        .o_granted_index   (o_granted_index),
        .o_index_valid     (o_index_valid),
        .o_last            (o_last),
        .o_status_code     (o_status),
        .o_allocated_total (o_allocated_total),
        .o_free_total      (o_free_total)
    );

endmodule

// ===== rtl/pia_ctrl.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pia_ctrl
// Sequencer: takes one input beat at a time and steps the datapath through
// the grants of an allocation, one per cycle the output side can take.
// ---------------------------------------------------------------------------
module pia_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  pia_pkg::t_status i_status,
    output logic             o_stall,
    output pia_pkg::t_cmd    o_cmd
);

    typedef enum logic {
        S_IDLE,
        S_RUN
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state      = r_state;
        o_cmd.accept = 1'b0;
        o_cmd.emit   = 1'b0;
        o_stall      = 1'b1;
        unique case (r_state)
            S_IDLE: begin
                o_stall      = !i_status.out_free;
                o_cmd.accept = i_valid && i_status.out_free;
                if (o_cmd.accept && i_status.alloc_go) begin
                    n_state = S_RUN;
                end
            end
            S_RUN: begin
                o_cmd.emit = i_status.out_free;
                if (o_cmd.emit && i_status.last_grant) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ===== rtl/pia_dpath.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pia_dpath
// Bump pointer, free stack memory with registered read, grant counters and
// the output register.
// ---------------------------------------------------------------------------
module pia_dpath (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  pia_pkg::t_cmd                i_cmd,
    output pia_pkg::t_status             o_status,
    input  logic [pia_pkg::FUNC_W-1:0]   i_func,
    input  logic [pia_pkg::PAGE_W-1:0]   i_free_page,
    input  logic [pia_pkg::BATCH_W-1:0]  i_batch_count,
    input  logic                         i_stall,
    output logic                         o_valid,
    output logic [pia_pkg::PAGE_W-1:0]   o_granted_index,
    output logic                         o_index_valid,
    output logic                         o_last,
    output logic [pia_pkg::STAT_W-1:0]   o_status_code,
    output logic [pia_pkg::CNT_W-1:0]    o_allocated_total,
    output logic [pia_pkg::CNT_W-1:0]    o_free_total
);

    localparam int PW = pia_pkg::PAGE_W;
    localparam int CW = pia_pkg::CNT_W;
    localparam int BW = pia_pkg::BATCH_W;
    localparam int SW = pia_pkg::STAT_W;

    // free stack, contents undefined until pushed
    logic [PW-1:0] mem [pia_pkg::POOL_PAGES];

    logic [CW-1:0] r_bump, n_bump;
    logic [CW-1:0] r_depth, n_depth;
    logic [PW-1:0] r_next, n_next;           // next bump index to grant
    logic [BW-1:0] r_fresh_left, n_fresh_left;
    logic [BW-1:0] r_left, n_left;           // grants still to emit
    logic [PW-1:0] r_pop_addr, n_pop_addr;   // address held in r_rd_data
    logic [PW-1:0] r_rd_data;

    logic          r_o_valid, n_o_valid;
    logic [PW-1:0] r_o_idx, n_o_idx;
    logic          r_o_ivalid, n_o_ivalid;
    logic          r_o_last, n_o_last;
    logic [SW-1:0] r_o_stat, n_o_stat;
    logic [CW-1:0] r_o_alloc, n_o_alloc;
    logic [CW-1:0] r_o_free, n_o_free;

    logic          is_single, is_batch, is_free;
    logic [BW-1:0] cnt_sat, want, popped, fresh;
    logic          exhaust, alloc_req, stack_full;
    logic          load;
    logic          rd_en;
    logic [PW-1:0] rd_addr;
    logic          wr_en;

    always_comb begin
        is_single  = (i_func == pia_pkg::FN_ALLOC);
        is_batch   = (i_func == pia_pkg::FN_BATCH);
        is_free    = (i_func == pia_pkg::FN_FREE);
        cnt_sat    = (i_batch_count > BW'(pia_pkg::MAX_BATCH)) ? BW'(pia_pkg::MAX_BATCH)
                                                               : i_batch_count;
        want       = is_single ? BW'(1) : cnt_sat;
        popped     = ({{(CW-BW){1'b0}}, want} < r_depth) ? want : r_depth[BW-1:0];
        fresh      = want - popped;
        exhaust    = ({1'b0, r_bump} + {{(CW+1-BW){1'b0}}, fresh})
                     > (CW+1)'(pia_pkg::POOL_PAGES);
        alloc_req  = is_single || (is_batch && (want != '0));
        stack_full = (r_depth >= CW'(pia_pkg::POOL_PAGES));
    end

    assign o_status.out_free   = !r_o_valid || !i_stall;
    assign o_status.alloc_go   = alloc_req && !exhaust;
    assign o_status.last_grant = (r_left == BW'(1));

    always_comb begin
        n_bump       = r_bump;
        n_depth      = r_depth;
        n_next       = r_next;
        n_fresh_left = r_fresh_left;
        n_left       = r_left;
        n_pop_addr   = r_pop_addr;
        rd_en        = 1'b0;
        rd_addr      = r_pop_addr - PW'(1);
        wr_en        = 1'b0;
        load         = 1'b0;
        n_o_idx      = '0;
        n_o_ivalid   = 1'b0;
        n_o_last     = 1'b1;
        n_o_stat     = pia_pkg::ST_OK;

        if (i_cmd.accept) begin
            if (alloc_req && exhaust) begin
                load     = 1'b1;
                n_o_stat = pia_pkg::ST_EXHAUSTED;
            end else if (alloc_req) begin
                // totals are reported as after the whole allocation
                n_bump       = r_bump + {{(CW-BW){1'b0}}, fresh};
                n_depth      = r_depth - {{(CW-BW){1'b0}}, popped};
                n_next       = r_bump[PW-1:0];
                n_fresh_left = fresh;
                n_left       = want;
                rd_en        = 1'b1;            // prefetch stack top
                rd_addr      = r_depth[PW-1:0] - PW'(1);
                n_pop_addr   = rd_addr;
            end else if (is_free) begin
                load = 1'b1;
                if (stack_full) begin
                    n_o_stat = pia_pkg::ST_DROPPED;
                end else begin
                    wr_en   = 1'b1;
                    n_depth = r_depth + CW'(1);
                end
            end
        end else if (i_cmd.emit) begin
            load       = 1'b1;
            n_o_ivalid = 1'b1;
            n_o_last   = (r_left == BW'(1));
            n_left     = r_left - BW'(1);
            if (r_fresh_left != '0) begin
                n_o_idx      = r_next;
                n_next       = r_next + PW'(1);
                n_fresh_left = r_fresh_left - BW'(1);
            end else begin
                n_o_idx    = r_rd_data;
                rd_en      = 1'b1;              // fetch the entry below
                n_pop_addr = r_pop_addr - PW'(1);
            end
        end

        n_o_alloc = (n_bump >= n_depth) ? (n_bump - n_depth) : '0;
        n_o_free  = n_depth;

        if (load) begin
            n_o_valid = 1'b1;
        end else if (!i_stall) begin
            n_o_valid = 1'b0;
        end else begin
            n_o_valid = r_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[r_depth[PW-1:0]] <= i_free_page;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rd_data <= mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bump    <= '0;
            r_depth   <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_bump    <= n_bump;
            r_depth   <= n_depth;
            r_o_valid <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_next       <= n_next;
        r_fresh_left <= n_fresh_left;
        r_left       <= n_left;
        r_pop_addr   <= n_pop_addr;
        if (load) begin
            r_o_idx    <= n_o_idx;
            r_o_ivalid <= n_o_ivalid;
            r_o_last   <= n_o_last;
            r_o_stat   <= n_o_stat;
            r_o_alloc  <= n_o_alloc;
            r_o_free   <= n_o_free;
        end
    end

    assign o_valid           = r_o_valid;
    assign o_granted_index   = r_o_idx;
    assign o_index_valid     = r_o_ivalid;
    assign o_last            = r_o_last;
    assign o_status_code     = r_o_stat;
    assign o_allocated_total = r_o_alloc;
    assign o_free_total      = r_o_free;

endmodule
